/* rtl/core/mlwa_pkg.sv */
// Package for the monospace line wrap and align block.
// Holds shared types, codes, widths and the fixed-point helper functions.
// No dependencies.
package mlwa_pkg;

    localparam int MAX_TEXT_LEN_DEF = 4096;

    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 20;
    localparam int OUT_W   = 13;
    localparam int LN_W    = 17;   // line count, covers the largest text length
    localparam int PITCH_W = 17;   // default pitch of a 16 bit size needs 17 bits
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    localparam logic [7:0] CHAR_END = 8'd0;
    localparam logic [7:0] CHAR_NL  = 8'd10;

    // (size * 27 + 10) / 20 as a reciprocal multiply, exact for n < 2^22
    localparam logic [20:0] PITCH_RECIP    = 21'd1677722;
    localparam int          PITCH_RECIP_SH = 25;
    localparam logic [PITCH_W-1:0] PITCH_RST = 17'd346;

    localparam logic signed [39:0] SAT_HI40 = 40'sd2147483647;
    localparam logic signed [39:0] SAT_LO40 = -40'sd2147483648;
    localparam logic signed [31:0] SAT_HI32 = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAT_LO32 = 32'sh80000000;

    typedef enum logic [CFG_IW-1:0] {
        REG_GLYPH_SIZE = 3'd0,
        REG_LETTER_SP  = 3'd1,
        REG_LINE_PITCH = 3'd2,
        REG_BOX_LEFT   = 3'd3,
        REG_BOX_TOP    = 3'd4,
        REG_BOX_WIDTH  = 3'd5,
        REG_BOX_HEIGHT = 3'd6,
        REG_ALIGNMENT  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_CENTER = 2'd1,
        ALIGN_RIGHT  = 2'd2,
        ALIGN_BAD    = 2'd3
    } align_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_INVALID  = 2'd1,
        STAT_TOO_LONG = 2'd2
    } stat_t;

    typedef struct packed {
        logic [15:0]        glyph_size;
        logic signed [15:0] letter_spacing;
        logic [PITCH_W-1:0] pitch;          // effective line pitch
        logic signed [19:0] box_left;
        logic signed [19:0] box_top;
        logic signed [19:0] box_width;
        logic signed [19:0] box_height;
        align_t             alignment;
    } cfg_t;

    typedef struct packed {
        logic [7:0] text_byte;
    } text_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]   line_offset;
        logic [OUT_W-1:0]   line_length;
        logic signed [31:0] line_x;
        logic signed [31:0] line_y;
        logic signed [31:0] line_width;
        logic [OUT_W-1:0]   line_number;
        logic               text_done;
        logic signed [31:0] widest_line;
        logic signed [31:0] total_height;
        logic [1:0]         status;
    } line_item_t;

    // line record handed from the front to the back
    typedef struct packed {
        logic [OUT_W-1:0]   offset;
        logic [OUT_W-1:0]   length;
        logic signed [31:0] width;
        logic signed [31:0] y;
        logic [LN_W-1:0]    count;
        logic               done;
        stat_t              status;
    } rec_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI40)
            r = SAT_HI32;
        else if (v < SAT_LO40)
            r = SAT_LO32;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [PITCH_W-1:0] default_pitch(input logic [15:0] size);
        logic [20:0] n;
        logic [41:0] prod;
        n = (21'(size) << 4) + (21'(size) << 3) + (21'(size) << 1) + 21'(size) + 21'd10;
        prod = 42'(n) * 42'(PITCH_RECIP);
        return prod[PITCH_RECIP_SH +: PITCH_W];
    endfunction

endpackage

/* rtl/core/mlwa_chan_if.sv */
// Valid/ready channel carrying one word of payload type T.
// Depends on nothing; payload types come from mlwa_pkg at the instance.
interface mlwa_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/mlwa_cfg.sv */
// Configuration registers and the derived default line pitch.
// Depends on mlwa_pkg.
module mlwa_cfg
    import mlwa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [CFG_IW-1:0] wr_index,
    input  logic [CFG_DW-1:0] wr_data,
    output cfg_t              cfg
);

    logic [15:0]        size_reg;
    logic signed [15:0] spacing_reg;
    logic [15:0]        pitch_reg;
    logic [PITCH_W-1:0] dflt_pitch_reg;
    logic signed [19:0] left_reg;
    logic signed [19:0] top_reg;
    logic signed [19:0] bw_reg;
    logic signed [19:0] bh_reg;
    align_t             align_reg;

    // default pitch is computed at the write, so it is ready with the size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= 16'd256;
            spacing_reg    <= '0;
            pitch_reg      <= '0;
            dflt_pitch_reg <= PITCH_RST;
            left_reg       <= '0;
            top_reg        <= '0;
            bw_reg         <= 20'sd16384;
            bh_reg         <= 20'sd16384;
            align_reg      <= ALIGN_LEFT;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_GLYPH_SIZE:
                begin
                    size_reg       <= wr_data[15:0];
                    dflt_pitch_reg <= default_pitch(wr_data[15:0]);
                end
                REG_LETTER_SP:  spacing_reg <= wr_data[15:0];
                REG_LINE_PITCH: pitch_reg   <= wr_data[15:0];
                REG_BOX_LEFT:   left_reg    <= wr_data;
                REG_BOX_TOP:    top_reg     <= wr_data;
                REG_BOX_WIDTH:  bw_reg      <= wr_data;
                REG_BOX_HEIGHT: bh_reg      <= wr_data;
                REG_ALIGNMENT:  align_reg   <= align_t'(wr_data[1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.glyph_size     = size_reg;
        cfg.letter_spacing = spacing_reg;
        cfg.pitch          = (pitch_reg != '0) ? PITCH_W'(pitch_reg) : dflt_pitch_reg;
        cfg.box_left       = left_reg;
        cfg.box_top        = top_reg;
        cfg.box_width      = bw_reg;
        cfg.box_height     = bh_reg;
        cfg.alignment      = align_reg;
    end

endmodule

/* rtl/core/mlwa_front.sv */
// Front end: takes one text byte per cycle while the queue has space, tracks the open line and
// pushes a line record at each line break and at the end byte. Depends on mlwa_pkg, mlwa_chan_if.
module mlwa_front
    import mlwa_pkg::*;
#(
    parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    mlwa_chan_if.sink chars,
    input  logic      q_space,
    output logic      push,
    output rec_t      rec
);

    localparam int CIW = $clog2(MAX_TEXT_LEN + 1);
    localparam logic [CIW-1:0] MAX_IDX = CIW'(MAX_TEXT_LEN);

    logic [CIW-1:0]     char_idx_reg, char_idx_next;
    logic [CIW-1:0]     line_start_reg, line_start_next;
    logic [CIW-1:0]     line_len_reg, line_len_next;
    logic signed [31:0] width_reg, width_next;
    logic signed [31:0] y_reg, y_next;
    logic [LN_W-1:0]    line_cnt_reg, line_cnt_next;
    stat_t              err_reg, err_next;
    logic               fresh_reg, fresh_next;

    logic               accept;
    logic [7:0]         c;
    logic               settings_ok;
    stat_t              err_now;
    logic signed [31:0] y_now;
    logic signed [31:0] y_step;
    logic signed [17:0] adv;
    logic signed [33:0] grow_sum;
    logic signed [33:0] new_sum;
    logic               wrap;

    assign chars.ready = q_space;
    assign accept      = chars.valid && chars.ready;
    assign c           = chars.data.text_byte;

    always_comb
    begin
        settings_ok = (cfg.glyph_size != '0) && (cfg.box_width > 20'sd0)
                   && (cfg.box_height > 20'sd0) && (cfg.alignment != ALIGN_BAD);
        err_now  = (err_reg == STAT_OK && !settings_ok) ? STAT_INVALID : err_reg;
        y_now    = fresh_reg ? 32'(cfg.box_top) : y_reg;
        y_step   = sat32(40'(y_now) + 40'(signed'({1'b0, cfg.pitch})));
        adv      = $signed({2'b00, cfg.glyph_size}) + 18'(cfg.letter_spacing);
        grow_sum = 34'(width_reg) + 34'(adv);
        // greedy wrap only on a line with positive width
        wrap     = (width_reg > 32'sd0) && (grow_sum > 34'(cfg.box_width));
        new_sum  = wrap ? 34'(adv) : grow_sum;
    end

    always_comb
    begin
        char_idx_next   = char_idx_reg;
        line_start_next = line_start_reg;
        line_len_next   = line_len_reg;
        width_next      = width_reg;
        y_next          = y_reg;
        line_cnt_next   = line_cnt_reg;
        err_next        = err_reg;
        fresh_next      = fresh_reg;
        push            = 1'b0;

        rec.offset = OUT_W'(line_start_reg);
        rec.length = OUT_W'(line_len_reg);
        rec.width  = width_reg;
        rec.y      = y_now;
        rec.count  = line_cnt_reg;
        rec.done   = 1'b0;
        rec.status = STAT_OK;

        if (accept)
        begin
            fresh_next = 1'b0;
            y_next     = y_now;
            if (c == CHAR_END)
            begin
                push     = 1'b1;
                rec.done = 1'b1;
                if (err_now != STAT_OK)
                begin
                    rec.offset = '0;
                    rec.length = '0;
                    rec.width  = '0;
                    rec.y      = '0;
                    rec.count  = '0;
                    rec.status = err_now;
                end
                char_idx_next   = '0;
                line_start_next = '0;
                line_len_next   = '0;
                width_next      = '0;
                y_next          = '0;
                line_cnt_next   = '0;
                err_next        = STAT_OK;
                fresh_next      = 1'b1;
            end
            else if (err_now != STAT_OK)
            begin
                err_next = err_now;
            end
            else if (char_idx_reg >= MAX_IDX)
            begin
                err_next = STAT_TOO_LONG;
            end
            else if (c == CHAR_NL)
            begin
                push            = 1'b1;
                line_cnt_next   = line_cnt_reg + LN_W'(1);
                y_next          = y_step;
                char_idx_next   = char_idx_reg + CIW'(1);
                line_start_next = char_idx_reg + CIW'(1);
                line_len_next   = '0;
                width_next      = '0;
            end
            else
            begin
                char_idx_next = char_idx_reg + CIW'(1);
                width_next    = sat32(40'(new_sum));
                if (wrap)
                begin
                    push            = 1'b1;
                    line_cnt_next   = line_cnt_reg + LN_W'(1);
                    y_next          = y_step;
                    line_start_next = char_idx_reg;
                    line_len_next   = CIW'(1);
                end
                else
                begin
                    line_len_next = line_len_reg + CIW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_idx_reg   <= '0;
            line_start_reg <= '0;
            line_len_reg   <= '0;
            width_reg      <= '0;
            y_reg          <= '0;
            line_cnt_reg   <= '0;
            err_reg        <= STAT_OK;
            fresh_reg      <= 1'b1;
        end
        else
        begin
            char_idx_reg   <= char_idx_next;
            line_start_reg <= line_start_next;
            line_len_reg   <= line_len_next;
            width_reg      <= width_next;
            y_reg          <= y_next;
            line_cnt_reg   <= line_cnt_next;
            err_reg        <= err_next;
            fresh_reg      <= fresh_next;
        end
    end

`ifndef SYNTH
    // with an error latched only the end byte makes a record
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_reg != STAT_OK && c != CHAR_END) |-> !push)
        else $error("record pushed while an error is latched");

    a_push_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (accept && q_space))
        else $error("record pushed without an accepted byte");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && c == CHAR_END) |=> (fresh_reg && char_idx_reg == '0 && err_reg == STAT_OK))
        else $error("text state not cleared after end byte");
`endif

endmodule

/* rtl/core/mlwa_fifo.sv */
// Short record queue between the front and back ends.
// Depends on mlwa_pkg.
module mlwa_fifo
    import mlwa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t wdata,
    input  logic pop,
    output logic space,
    output logic not_empty,
    output rec_t head
);

    rec_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   cnt_reg, cnt_next;

    assign space     = (cnt_reg != (QAW+1)'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        QAW'(wr_ptr_reg - rd_ptr_reg) == cnt_reg[QAW-1:0])
        else $error("queue pointers and count disagree");
`endif

endmodule

/* rtl/core/mlwa_back.sv */
// Back end: turns line records into result words (alignment x, running
// widest line, total height) over two stages. Depends on mlwa_pkg, mlwa_chan_if.
module mlwa_back
    import mlwa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_vld,
    input  rec_t        head,
    output logic        pop,
    mlwa_chan_if.source lines
);

    localparam int PROD_W = LN_W + PITCH_W;

    logic               en;
    logic [LN_W-1:0]    cnt_inc;
    logic signed [33:0] diff;
    logic signed [33:0] xoff;
    logic [PROD_W-1:0]  prod;
    logic signed [31:0] widest;
    logic signed [31:0] max_next;
    line_item_t         out_next;

    logic               a_vld_reg;
    rec_t               a_rec_reg;
    logic signed [33:0] a_xoff_reg;
    logic [PROD_W-1:0]  a_prod_reg;
    logic signed [31:0] a_widest_reg;
    logic signed [31:0] max_reg;
    logic               o_vld_reg;
    line_item_t         o_data_reg;

    // the output register frees whenever its word is taken
    assign en  = !o_vld_reg || lines.ready;
    assign pop = q_vld && en;

    always_comb
    begin
        cnt_inc = head.count + LN_W'(1);
        prod    = PROD_W'(cnt_inc) * PROD_W'(cfg.pitch);
        diff    = 34'(cfg.box_width) - 34'(head.width);
        case (cfg.alignment)
            ALIGN_CENTER: xoff = diff >>> 1;
            ALIGN_RIGHT:  xoff = diff;
            default:      xoff = '0;
        endcase
        widest = (head.width > max_reg) ? head.width : max_reg;
        if (head.status != STAT_OK)
            widest = '0;
        max_next = head.done ? 32'sd0 : widest;
    end

    always_comb
    begin
        out_next = '0;
        out_next.text_done = a_rec_reg.done;
        out_next.status    = a_rec_reg.status;
        if (a_rec_reg.status == STAT_OK)
        begin
            out_next.line_offset  = a_rec_reg.offset;
            out_next.line_length  = a_rec_reg.length;
            out_next.line_x       = sat32(40'(cfg.box_left) + 40'(a_xoff_reg));
            out_next.line_y       = a_rec_reg.y;
            out_next.line_width   = a_rec_reg.width;
            out_next.line_number  = a_rec_reg.count[OUT_W-1:0];
            out_next.widest_line  = a_widest_reg;
            out_next.total_height = sat32(40'(signed'({1'b0, a_prod_reg})));
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_rec_reg    <= head;
            a_xoff_reg   <= xoff;
            a_prod_reg   <= prod;
            a_widest_reg <= widest;
        end
        if (en)
            o_data_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            max_reg   <= '0;
        end
        else if (en)
        begin
            a_vld_reg <= q_vld;
            o_vld_reg <= a_vld_reg;
            if (pop)
                max_reg <= max_next;
        end
    end

    assign lines.valid = o_vld_reg;
    assign lines.data  = o_data_reg;

`ifndef SYNTH
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (a_vld_reg && a_rec_reg.status != STAT_OK) |-> a_rec_reg.done)
        else $error("error record that does not end the text");

    a_max_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.done) |=> (max_reg == 32'sd0))
        else $error("widest line not cleared at end of text");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (o_vld_reg && lines.data.status != STAT_OK)
            |-> (lines.data.widest_line == 32'sd0 && lines.data.line_width == 32'sd0))
        else $error("error result carries line data");
`endif

endmodule

/* rtl/core/monospace_line_wrap_align.sv */
// Monospaced greedy line wrap with left, center or right alignment. The block
// takes one text byte per clock cycle, sustained, for as long as result words
// are taken; each byte's step is one add and compare of the open line's width
// in the front end, which sets that rate. A line break pushes a record into a
// four-entry queue; the back end pops it into its first stage and then into
// the output register, from which the line result leaves. A zero byte ends
// the text and always gives one result. Configuration registers take effect
// on the next byte; write them only while no results are pending. Depends on
// mlwa_pkg, mlwa_chan_if, mlwa_cfg, mlwa_front, mlwa_fifo and mlwa_back.
module monospace_line_wrap_align
    import mlwa_pkg::*;
#(
    parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [CFG_IW-1:0] wr_index,
    input  logic [CFG_DW-1:0] wr_data,
    mlwa_chan_if.sink         chars,
    mlwa_chan_if.source       lines
);

    cfg_t cfg;
    logic push;
    rec_t rec;
    logic pop;
    logic q_space;
    logic q_vld;
    rec_t q_head;

    mlwa_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    mlwa_front #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .chars   (chars),
        .q_space (q_space),
        .push    (push),
        .rec     (rec)
    );

    mlwa_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (rec),
        .pop       (pop),
        .space     (q_space),
        .not_empty (q_vld),
        .head      (q_head)
    );

    mlwa_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .q_vld (q_vld),
        .head  (q_head),
        .pop   (pop),
        .lines (lines)
    );

endmodule
